FILE: src/refcounted_page_allocator_defines.svh
// Assertion macros for the page allocator.
// No dependencies; included by the files that carry assertions.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("page allocator: check failed");

// Next-cycle implication, disabled while reset is held.
`define PRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("page allocator: check failed");

`endif

FILE: src/pra_pkg.sv
// Shared constants and types of the page allocator.
// No dependencies.
package pra_pkg;

  localparam int ADDR_W   = 27;  // byte offset field
  localparam int FUP_W    = 15;  // first usable page register
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 8;   // reported count field

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_ADDREF = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  // Decision of the update unit for one item
  typedef struct packed {
    logic                ref_we;
    logic                stk_we;
    logic                fc_inc;
    logic                fc_dec;
    logic                returned;
    logic [STATUS_W-1:0] status;
  } pra_ctl_t;

endpackage

FILE: src/pra_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/pra_exec.sv
// Update unit: decides the count and stack writes and the result of one item.
// Depends on pra_pkg.
module pra_exec #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 8,
  localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1,
  localparam int FC_W   = $clog2(NUM_PAGES + 1)
) (
  input  logic [1:0]                 cmd,
  input  logic                       bad,
  input  logic [PAGE_W-1:0]          page,
  input  logic [FC_W-1:0]            free_count,
  input  logic [REF_BITS-1:0]        ref_rdata,
  input  logic [PAGE_W-1:0]          stk_rdata,
  output pra_pkg::pra_ctl_t          ctl,
  output logic [PAGE_W-1:0]          ref_waddr,
  output logic [REF_BITS-1:0]        ref_wdata,
  output logic [pra_pkg::ADDR_W-1:0] page_addr,
  output logic [pra_pkg::CNT_W-1:0]  cnt_after
);

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  logic [63:0]         pa_wide;
  logic [39:0]         cnt_wide;
  logic [REF_BITS-1:0] cnt_val;
  logic                empty;
  logic                full;

  assign empty   = (free_count == '0);
  assign full    = (free_count == FC_W'(NUM_PAGES));
  assign pa_wide = 64'(stk_rdata) << PAGE_SHIFT;

  always_comb begin
    ctl       = '0;
    ctl.status = pra_pkg::ST_BADADDR;
    ref_waddr = page;
    ref_wdata = '0;
    page_addr = '0;
    cnt_val   = '0;
    case (cmd)
      pra_pkg::CMD_ALLOC: begin
        if (empty) begin
          ctl.status = pra_pkg::ST_OOM;
        end else begin
          ctl.status = pra_pkg::ST_OK;
          ctl.fc_dec = 1'b1;
          ctl.ref_we = 1'b1;
          ref_waddr  = stk_rdata;
          ref_wdata  = REF_ONE;
          page_addr  = pa_wide[pra_pkg::ADDR_W-1:0];
          cnt_val    = REF_ONE;
        end
      end
      pra_pkg::CMD_FREE: begin
        if (!bad) begin
          ctl.ref_we = 1'b1;
          if (ref_rdata > REF_ONE) begin
            ctl.status = pra_pkg::ST_OK;
            ref_wdata  = ref_rdata - REF_ONE;
            cnt_val    = ref_rdata - REF_ONE;
          end else if (full) begin
            ctl.status = pra_pkg::ST_FULL;
          end else begin
            ctl.status   = pra_pkg::ST_OK;
            ctl.stk_we   = 1'b1;
            ctl.fc_inc   = 1'b1;
            ctl.returned = 1'b1;
          end
        end
      end
      pra_pkg::CMD_ADDREF: begin
        if (!bad) begin
          if (ref_rdata == REF_MAX) begin
            ctl.status = pra_pkg::ST_SAT;
            cnt_val    = REF_MAX;
          end else begin
            ctl.status = pra_pkg::ST_OK;
            ctl.ref_we = 1'b1;
            ref_wdata  = ref_rdata + REF_ONE;
            cnt_val    = ref_rdata + REF_ONE;
          end
        end
      end
      default: begin
        ctl.status = pra_pkg::ST_BADADDR;
      end
    endcase
  end

  assign cnt_wide  = 40'(cnt_val);
  assign cnt_after = cnt_wide[pra_pkg::CNT_W-1:0];

endmodule

FILE: src/refcounted_page_allocator.sv
// Top level of the reference-counted page allocator.
// Depends on pra_pkg, pra_ram, pra_exec and refcounted_page_allocator_defines.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tuser: cmd; tdata: addr_offset
//  out_    | master    | out_tvalid/out_tready| tuser: status; tdata: page_addr,
//          |           |                      |   returned_to_pool, ref_count_after
//  cfg_    | write     | cfg_we               | cfg_wdata: first_usable_page
//
// An item is read from the count RAM and the stack RAM at accept, then decided
// and written back in the write-back state. Both RAMs are single-write, single-read.
// After reset a clearing pass zeroes every count RAM entry with in_tready low;
// configuration writes are taken throughout.
// The result sits in an output register, so the next item is taken while a
// result waits; the write-back cycle stalls only if that register is still full.
`include "refcounted_page_allocator_defines.svh"

module refcounted_page_allocator #(
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  parameter int REF_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // slave side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // [1:0] cmd
  input  logic [31:0] in_tdata,    // [26:0] addr_offset, [31:27] zero
  // master side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,   // [2:0] status
  output logic [39:0] out_tdata,   // [26:0] page_addr, [27] returned_to_pool,
                                   // [35:28] ref_count_after, [39:36] zero
  // configuration
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata    // first_usable_page
);

  localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FC_W   = $clog2(NUM_PAGES + 1);
  localparam int AW     = pra_pkg::ADDR_W;
  localparam logic [AW-1:0] LOW_MASK = (AW'(1) << PAGE_SHIFT) - AW'(1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t                      state_r;
  logic [PAGE_W-1:0]           clr_idx_r;
  logic [FC_W-1:0]             fc_r;
  logic [pra_pkg::FUP_W-1:0]   fup_r;
  logic [1:0]                  cmd_r;
  logic                        bad_r;
  logic [PAGE_W-1:0]           page_r;
  logic                        out_valid_r;
  logic [pra_pkg::STATUS_W-1:0] out_status_r;
  logic [AW-1:0]               out_paddr_r;
  logic                        out_ret_r;
  logic [pra_pkg::CNT_W-1:0]   out_cnt_r;

  logic                        accept;
  logic                        go;
  logic [AW-1:0]               addr;
  logic [31:0]                 page32;
  logic                        bad_nxt;
  logic [FC_W-1:0]             fc_m1;
  logic [REF_BITS-1:0]         ref_rdata;
  logic [PAGE_W-1:0]           stk_rdata;
  pra_pkg::pra_ctl_t           ctl;
  logic [PAGE_W-1:0]           ex_ref_waddr;
  logic [REF_BITS-1:0]         ex_ref_wdata;
  logic [AW-1:0]               ex_paddr;
  logic [pra_pkg::CNT_W-1:0]   ex_cnt;
  logic                        ref_we;
  logic [PAGE_W-1:0]           ref_waddr;
  logic [REF_BITS-1:0]         ref_wdata;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  // write-back proceeds once the output register has room
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // address checks done at accept, so the write-back cycle only decides
  assign addr   = in_tdata[AW-1:0];
  assign page32 = 32'(addr >> PAGE_SHIFT);
  assign fc_m1  = fc_r - FC_W'(1);

  always_comb begin
    case (in_tuser)
      pra_pkg::CMD_ALLOC:  bad_nxt = 1'b0;
      pra_pkg::CMD_FREE:   bad_nxt = ((addr & LOW_MASK) != '0)
                                  || (page32 < 32'(fup_r))
                                  || (page32 >= 32'(NUM_PAGES));
      pra_pkg::CMD_ADDREF: bad_nxt = (page32 >= 32'(NUM_PAGES));
      default:             bad_nxt = 1'b1;
    endcase
  end

  // count RAM: clearing pass owns the write port until done
  assign ref_we    = (state_r == S_CLEAR) || (go && ctl.ref_we);
  assign ref_waddr = (state_r == S_CLEAR) ? clr_idx_r : ex_ref_waddr;
  assign ref_wdata = (state_r == S_CLEAR) ? '0 : ex_ref_wdata;

  pra_ram #(.WIDTH(REF_BITS), .DEPTH(NUM_PAGES)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .re    (accept),
    .raddr (page32[PAGE_W-1:0]),
    .rdata (ref_rdata)
  );

  // free stack: top entry read at accept, push at write-back
  pra_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stk_ram (
    .clk   (clk),
    .we    (go && ctl.stk_we),
    .waddr (fc_r[PAGE_W-1:0]),
    .wdata (page_r),
    .re    (accept),
    .raddr (fc_m1[PAGE_W-1:0]),
    .rdata (stk_rdata)
  );

  pra_exec #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .REF_BITS   (REF_BITS)
  ) u_exec (
    .cmd        (cmd_r),
    .bad        (bad_r),
    .page       (page_r),
    .free_count (fc_r),
    .ref_rdata  (ref_rdata),
    .stk_rdata  (stk_rdata),
    .ctl        (ctl),
    .ref_waddr  (ex_ref_waddr),
    .ref_wdata  (ex_ref_wdata),
    .page_addr  (ex_paddr),
    .cnt_after  (ex_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      fc_r        <= '0;
      fup_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        fup_r <= cfg_wdata;
      end
      // a write-back in the same cycle refills the register instead
      if (out_valid_r && out_tready && !go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + PAGE_W'(1);
          if (clr_idx_r == PAGE_W'(NUM_PAGES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
            cmd_r   <= in_tuser;
            bad_r   <= bad_nxt;
            page_r  <= page32[PAGE_W-1:0];
          end
        end
        S_EXEC: begin
          if (go) begin
            state_r      <= S_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= ctl.status;
            out_paddr_r  <= ex_paddr;
            out_ret_r    <= ctl.returned;
            out_cnt_r    <= ex_cnt;
            if (ctl.fc_inc) begin
              fc_r <= fc_r + FC_W'(1);
            end else if (ctl.fc_dec) begin
              fc_r <= fc_m1;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0, out_cnt_r, out_ret_r, out_paddr_r};

  // stack pointer never passes the pool size
  `PRA_ASSERT_NOW(a_fc_bound, clk, rst_n, 1'b1, fc_r <= FC_W'(NUM_PAGES))
  // a push only happens with room on the stack
  `PRA_ASSERT_NOW(a_push_room, clk, rst_n, go && ctl.stk_we, fc_r != FC_W'(NUM_PAGES))
  // an accepted item moves straight to write-back
  `PRA_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == S_EXEC)
  // a result appears only out of a write-back cycle
  `PRA_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_valid_r), $past(go))

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_page_allocator: a directed table, random
// allocate/free/add-reference traffic over several floors and a long receiver stall.
// Depends on pra_pkg and the allocator RTL only.
module testbench;

  localparam int NUM_PAGES   = 32768;
  localparam int PAGE_SHIFT  = 12;
  localparam int REF_BITS    = 8;
  // clearing pass + ~1.2k items at worst gaps on both sides, with a wide margin
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [1:0]                CMD_UNUSED = 2'd3;  // no operation behind it
  localparam logic [pra_pkg::CNT_W-1:0] REF_MAX    = 8'hFF;

  // one result item, as the predictor sees it
  typedef struct packed {
    logic [pra_pkg::STATUS_W-1:0] status;
    logic [pra_pkg::ADDR_W-1:0]   page_addr;
    logic                         returned;
    logic [pra_pkg::CNT_W-1:0]    refs_after;
  } page_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed table row; for ROW_CFG the floor value sits in addr
  typedef struct {
    row_kind_t                  kind;
    logic [1:0]                 cmd;
    logic [pra_pkg::ADDR_W-1:0] addr;
    bit                         typed;
    page_result_t               want;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;   // [1:0] cmd
  logic [31:0] in_tdata   = '0;   // [26:0] addr_offset, [31:27] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;         // [2:0] status
  logic [39:0] out_tdata;         // [26:0] page_addr, [27] returned, [35:28] count, [39:36] 0
  logic        cfg_we     = 1'b0;
  logic [14:0] cfg_wdata  = '0;   // first_usable_page

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  refcounted_page_allocator #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SHIFT(PAGE_SHIFT),
    .REF_BITS  (REF_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: LIFO of page indices, per-page counts, the floor register
  // ---------------------------------------------------------------------------
  logic [pra_pkg::FUP_W-1:0] pool_stack [NUM_PAGES];
  int unsigned               pool_depth;
  logic [pra_pkg::CNT_W-1:0] page_refs  [NUM_PAGES];
  logic [pra_pkg::FUP_W-1:0] usable_floor;

  page_result_t awaited_results [$];   // one per accepted item, oldest first
  int           held_pages [$];        // pages believed in use, for well-formed traffic

  bit idle_on       = 1'b1;            // cleared for stretches with no gaps at all
  bit pressure_done = 1'b0;
  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int floor_writes  = 0;
  int longest_hold  = 0;
  int status_seen [8];

  function automatic logic [pra_pkg::ADDR_W-1:0] page_base(input int pg);
    return pra_pkg::ADDR_W'(pg) << PAGE_SHIFT;
  endfunction

  // Works out the result of one item and moves the predictor state on.
  // The page index is 15 bits wide here, so it can never reach NUM_PAGES.
  function automatic page_result_t apply_page_op(input logic [1:0] cmd,
                                                 input logic [pra_pkg::ADDR_W-1:0] addr);
    page_result_t              r;
    logic [pra_pkg::FUP_W-1:0] pg;
    r  = '0;
    pg = addr[pra_pkg::ADDR_W-1:PAGE_SHIFT];
    case (cmd)
      pra_pkg::CMD_ALLOC: begin
        if (pool_depth == 0) begin
          r.status = pra_pkg::ST_OOM;
        end else begin
          pool_depth    = pool_depth - 1;
          pg            = pool_stack[pool_depth];
          page_refs[pg] = 8'd1;
          r.status      = pra_pkg::ST_OK;
          r.page_addr   = page_base(int'(pg));
          r.refs_after  = 8'd1;
        end
      end
      pra_pkg::CMD_FREE: begin
        if (addr[PAGE_SHIFT-1:0] != '0 || pg < usable_floor) begin
          r.status = pra_pkg::ST_BADADDR;
        end else if (page_refs[pg] > 8'd1) begin
          page_refs[pg] = page_refs[pg] - 8'd1;
          r.status      = pra_pkg::ST_OK;
          r.refs_after  = page_refs[pg];
        end else begin
          // count dropped even when the stack has no room
          page_refs[pg] = '0;
          if (pool_depth >= NUM_PAGES) begin
            r.status = pra_pkg::ST_FULL;
          end else begin
            pool_stack[pool_depth] = pg;
            pool_depth             = pool_depth + 1;
            r.status               = pra_pkg::ST_OK;
            r.returned             = 1'b1;
          end
        end
      end
      pra_pkg::CMD_ADDREF: begin
        if (page_refs[pg] == REF_MAX) begin
          r.status = pra_pkg::ST_SAT;
        end else begin
          page_refs[pg] = page_refs[pg] + 8'd1;
          r.status      = pra_pkg::ST_OK;
        end
        r.refs_after = page_refs[pg];
      end
      default: r.status = pra_pkg::ST_BADADDR;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. Always entered and left just after a rising edge. valid stays
  // high between back-to-back items; the expectation is queued on acceptance.
  // ---------------------------------------------------------------------------
  task automatic offer_page_op(input logic [1:0] cmd, input logic [pra_pkg::ADDR_W-1:0] addr,
                               input bit typed, input page_result_t want,
                               output page_result_t got);
    int gap;
    gap = idle_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = apply_page_op(cmd, addr);
    awaited_results.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [pra_pkg::ADDR_W-1:0] addr,
                       output page_result_t got);
    offer_page_op(cmd, addr, 1'b0, '0, got);
  endtask

  // Every item answers once, so an empty queue means the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_floor(input logic [pra_pkg::FUP_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    usable_floor = value;
    floor_writes++;
  endtask

  // Mixed traffic: allocations, frees and extra references on pages in use, stray
  // frees around the floor, and raw noise on every field (unused command too).
  task automatic random_traffic(input int count);
    page_result_t got;
    int           pick;
    int           k;
    int           pg;
    int           span;
    span = NUM_PAGES - 1 - int'(usable_floor);
    if (span > 63) span = 63;
    for (int i = 0; i < count; i++) begin
      if (i % 48 == 0) idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        issue(pra_pkg::CMD_ALLOC, pra_pkg::ADDR_W'($urandom), got);
        if (got.status == pra_pkg::ST_OK)
          held_pages.push_back(int'(got.page_addr >> PAGE_SHIFT));
      end else if (pick < 55 && held_pages.size() != 0) begin
        k = $urandom_range(0, held_pages.size() - 1);
        issue(pra_pkg::CMD_FREE, page_base(held_pages[k]), got);
        // gone back to the pool, or no longer freeable under this floor
        if (got.returned || got.status != pra_pkg::ST_OK) held_pages.delete(k);
      end else if (pick < 75 && held_pages.size() != 0) begin
        k = $urandom_range(0, held_pages.size() - 1);
        // low bits are dropped by add-reference
        issue(pra_pkg::CMD_ADDREF,
              page_base(held_pages[k]) | pra_pkg::ADDR_W'($urandom_range(0, 4095)), got);
      end else if (pick < 88) begin
        if ($urandom_range(0, 1) == 1) pg = $urandom_range(0, NUM_PAGES - 1);
        else pg = int'(usable_floor) + $urandom_range(0, span);
        issue(pra_pkg::CMD_FREE, page_base(pg), got);
      end else begin
        issue(2'($urandom_range(0, 3)), pra_pkg::ADDR_W'($urandom), got);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold once traffic is flowing,
  // field-by-field compare against the oldest expectation.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int           hold;
    page_result_t want;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        results_seen++;
        status_seen[out_tuser]++;
        if (awaited_results.size() == 0) begin
          note_mismatch("result with nothing awaited", out_tuser, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser != want.status)
            note_mismatch("status", out_tuser, want.status);
          if (out_tdata[26:0] != want.page_addr)
            note_mismatch("page_addr", out_tdata[26:0], want.page_addr);
          if (out_tdata[27] != want.returned)
            note_mismatch("returned_to_pool", out_tdata[27], want.returned);
          if (out_tdata[35:28] != want.refs_after)
            note_mismatch("ref_count_after", out_tdata[35:28], want.refs_after);
        end
      end
      if (hold > 0) begin
        hold--;
      end else if (!pressure_done && results_seen >= 200) begin
        // long hold-off: the sender keeps offering, so the block backs up
        hold          = 600;
        pressure_done = 1'b1;
      end else if (idle_on) begin
        hold = idle_gap();
      end
      if (hold > longest_hold) longest_hold = hold;
      out_tready <= (hold == 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("no finish after %0d cycles, %0d results still awaited",
             cycles, awaited_results.size());
    $display("[refcounted_page_allocator] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    page_result_t              got;
    page_result_t              hammered;
    dir_row_t                  rows [$];
    dir_row_t                  row;
    logic [pra_pkg::FUP_W-1:0] floors [5];
    int                        pg;
    int                        span;

    for (int p = 0; p < NUM_PAGES; p++) page_refs[p] = '0;
    pool_depth   = 0;
    usable_floor = '0;

    // Directed table. Typed expectations only where obvious; the rest go through
    // the predictor. Counts start at zero and the stack is empty after reset.
    row = '{ROW_ITEM, pra_pkg::CMD_ALLOC, '0, 1'b0, '0};
    // floor register at its low extreme
    row.kind = ROW_CFG;  row.addr = '0;  rows.push_back(row);
    row.kind = ROW_ITEM;
    // allocate from an empty pool
    row.cmd = pra_pkg::CMD_ALLOC;  row.addr = '0;  row.typed = 1;
    row.want = '{pra_pkg::ST_OOM, '0, 1'b0, 8'd0};  rows.push_back(row);
    // unaligned frees, lowest and highest offsets
    row.cmd = pra_pkg::CMD_FREE;  row.addr = 27'h0000001;
    row.want = '{pra_pkg::ST_BADADDR, '0, 1'b0, 8'd0};  rows.push_back(row);
    row.addr = 27'h7FFFFFF;  rows.push_back(row);
    // unused command
    row.cmd = CMD_UNUSED;  rows.push_back(row);
    // add-reference rounds the offset down to the top page
    row.cmd = pra_pkg::CMD_ADDREF;  row.want = '{pra_pkg::ST_OK, '0, 1'b0, 8'd1};
    rows.push_back(row);
    // count of one: free returns the top page to the pool
    row.cmd = pra_pkg::CMD_FREE;  row.addr = 27'h7FFF000;
    row.want = '{pra_pkg::ST_OK, '0, 1'b1, 8'd0};  rows.push_back(row);
    row.cmd = pra_pkg::CMD_ALLOC;  row.addr = '0;
    row.want = '{pra_pkg::ST_OK, 27'h7FFF000, 1'b0, 8'd1};  rows.push_back(row);
    // shared page: second reference, then two frees, then a double free
    row.typed = 0;
    row.cmd = pra_pkg::CMD_ADDREF;  row.addr = 27'h7FFF123;  rows.push_back(row);
    row.cmd = pra_pkg::CMD_FREE;    row.addr = 27'h7FFF000;  rows.push_back(row);
    rows.push_back(row);
    rows.push_back(row);
    // the twice-pushed page comes out twice; allocate ignores the address
    row.cmd = pra_pkg::CMD_ALLOC;  row.addr = 27'h7FFFFFF;  rows.push_back(row);
    row.addr = '0;  rows.push_back(row);
    row.typed = 1;  row.want = '{pra_pkg::ST_OOM, '0, 1'b0, 8'd0};  rows.push_back(row);
    // page zero, and an add-reference on a page sitting in the pool
    row.typed = 0;
    row.cmd = pra_pkg::CMD_FREE;    row.addr = 27'h0000000;  rows.push_back(row);
    row.cmd = pra_pkg::CMD_ADDREF;  row.addr = 27'h0000FFF;  rows.push_back(row);
    row.cmd = CMD_UNUSED;  row.addr = '0;  row.typed = 1;
    row.want = '{pra_pkg::ST_BADADDR, '0, 1'b0, 8'd0};  rows.push_back(row);
    // floor at its top: only the last page may be freed
    row.kind = ROW_CFG;  row.addr = 27'h0007FFF;  rows.push_back(row);
    row.kind = ROW_ITEM;
    row.cmd = pra_pkg::CMD_FREE;  row.addr = 27'h7FFE000;  rows.push_back(row);
    row.typed = 0;  row.addr = 27'h7FFF000;  rows.push_back(row);
    row.cmd = pra_pkg::CMD_ALLOC;  row.addr = '0;  rows.push_back(row);
    // floor in the middle: just below and exactly at it
    row.kind = ROW_CFG;  row.addr = 27'h0004000;  rows.push_back(row);
    row.kind = ROW_ITEM;
    row.cmd = pra_pkg::CMD_FREE;  row.addr = 27'h3FFF000;  row.typed = 1;
    row.want = '{pra_pkg::ST_BADADDR, '0, 1'b0, 8'd0};  rows.push_back(row);
    row.typed = 0;  row.addr = 27'h4000000;  rows.push_back(row);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // in_tready stays low through the clearing pass; the sender simply waits
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_floor(rows[i].addr[pra_pkg::FUP_W-1:0]);
      else offer_page_op(rows[i].cmd, rows[i].addr, rows[i].typed, rows[i].want, got);
    end

    // Random phases, each under its own floor, extremes among them
    floors[0] = '0;
    floors[1] = pra_pkg::FUP_W'($urandom_range(1, NUM_PAGES - 2));
    floors[2] = '1;
    floors[3] = pra_pkg::FUP_W'($urandom_range(1, 64));
    floors[4] = pra_pkg::FUP_W'($urandom_range(NUM_PAGES - 200, NUM_PAGES - 2));
    for (int ph = 0; ph < 5; ph++) begin
      write_floor(floors[ph]);
      idle_on = 1'b1;
      held_pages.delete();
      span = NUM_PAGES - 1 - int'(usable_floor);
      if (span > 63) span = 63;
      // stock the pool with pages this floor accepts
      repeat (24) begin
        pg = int'(usable_floor) + $urandom_range(0, span);
        issue(pra_pkg::CMD_FREE, page_base(pg), got);
      end
      if (ph == 0) begin
        // drive one page's count into saturation and past it
        issue(pra_pkg::CMD_ALLOC, '0, hammered);
        held_pages.push_back(int'(hammered.page_addr >> PAGE_SHIFT));
        repeat (int'(REF_MAX) + 5)
          issue(pra_pkg::CMD_ADDREF,
                hammered.page_addr | pra_pkg::ADDR_W'($urandom_range(0, 4095)), got);
      end
      random_traffic(140);
    end

    // last stretch back at the lowest floor
    write_floor('0);
    idle_on = 1'b1;
    held_pages.delete();
    random_traffic(60);

    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d items over %0d floor settings, incl. a saturated count and a %0d-cycle hold",
             items_sent, floor_writes, longest_hold);
    $display("statuses seen: ok %0d, out of pages %0d, bad address %0d, saturated %0d, full %0d",
             status_seen[pra_pkg::ST_OK], status_seen[pra_pkg::ST_OOM],
             status_seen[pra_pkg::ST_BADADDR], status_seen[pra_pkg::ST_SAT],
             status_seen[pra_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("[refcounted_page_allocator] OK");
    end else begin
      $display("[refcounted_page_allocator] ERROR");
    end
    $finish;
  end

endmodule
